// ===== rtl/ordered_list_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Ordered list engine assertion macros
// Clocked, reset-qualified concurrent checks used by the top-level file.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define OLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/olist_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list engine package
// Request/response payloads, action and status codes, controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

package olist_pkg;

    localparam logic [2:0] ACT_INSERT   = 3'd0;
    localparam logic [2:0] ACT_FIND     = 3'd1;
    localparam logic [2:0] ACT_DELETE   = 3'd2;
    localparam logic [2:0] ACT_FROM_END = 3'd3;
    localparam logic [2:0] ACT_MIDDLE   = 3'd4;
    localparam logic [2:0] ACT_LENGTH   = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] item_value;
        logic [4:0]         position;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         found_index;
        logic signed [31:0] read_value;
        logic [4:0]         list_length;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request
        logic compare;  // register per-cell match vector
        logic select;   // isolate first match
        logic commit;   // update cells, count and response register
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/olist_req_if.sv =====
// ----------------------------------------------------------------------------
// Ordered list request channel
// Valid/ready channel carrying one action request.
// ----------------------------------------------------------------------------
`default_nettype none

interface olist_req_if;
    logic             valid;
    logic             ready;
    olist_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/olist_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Ordered list response channel
// Valid/ready channel carrying one action result.
// ----------------------------------------------------------------------------
`default_nettype none

interface olist_rsp_if;
    logic             valid;
    logic             ready;
    olist_pkg::t_rsp  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/olist_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ordered list controller
// Sequences compare, select and commit steps; owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output olist_pkg::t_cmd  o_cmd
);
    import olist_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_SELECT,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_slot_free;

    // response register free, or emptied this cycle
    assign w_slot_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = i_in_valid && (r_state == S_IDLE);
        o_cmd.compare = (r_state == S_COMPARE);
        o_cmd.select  = (r_state == S_SELECT);
        o_cmd.commit  = (r_state == S_COMMIT) && w_slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_COMPARE;
                    end
                end
                S_COMPARE: begin
                    r_state <= S_SELECT;
                end
                S_SELECT: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (w_slot_free) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/olist_dp.sv =====
// ----------------------------------------------------------------------------
// Ordered list datapath
// Row of entry cells with parallel compare, first-match select and shift.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_dp #(
    parameter int CAPACITY = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire olist_pkg::t_cmd  i_cmd,
    input  wire olist_pkg::t_req  i_req,
    output olist_pkg::t_rsp       o_rsp
);
    import olist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);   // count width
    localparam int IW = $clog2(CAPACITY);       // index width
    localparam int PW = (CW > 5) ? CW : 5;      // compare width for position vs count

    logic [31:0]         r_cell [CAPACITY];
    logic [31:0]         n_cell [CAPACITY];
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    t_req                r_req;
    logic [CAPACITY-1:0] r_match;
    logic [CAPACITY-1:0] n_match;
    logic [CAPACITY-1:0] r_onehot;
    logic                r_hit;
    t_rsp                r_rsp;
    t_rsp                n_rsp;

    logic [IW-1:0]       w_hit_idx;
    logic [CAPACITY-1:0] w_at_or_after;
    logic [PW-1:0]       w_pos;
    logic [PW-1:0]       w_cnt;
    logic [PW-1:0]       w_ins_pos;
    logic                w_full;
    logic                w_fe_ok;
    logic [IW-1:0]       w_fe_idx;
    logic [IW-1:0]       w_mid_idx;
    logic [IW-1:0]       w_rd_idx;
    logic [31:0]         w_rd_data;

    // per-cell equality, masked to occupied cells
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_match[i] = (CW'(i) < r_count) && (r_cell[i] == r_req.item_value);
        end
    end

    // one-hot of first match to index
    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_onehot[i]) begin
                w_hit_idx = w_hit_idx | IW'(i);
            end
        end
    end

    assign w_at_or_after = ~(r_onehot - CAPACITY'(1));

    assign w_pos     = PW'(r_req.position);
    assign w_cnt     = PW'(r_count);
    assign w_ins_pos = (w_pos > w_cnt) ? w_cnt : w_pos;
    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_fe_ok   = (w_pos < w_cnt);
    assign w_fe_idx  = IW'(w_cnt - PW'(1) - w_pos);
    assign w_mid_idx = IW'((r_count - CW'(1)) >> 1);
    assign w_rd_idx  = (r_req.action == ACT_FROM_END) ? w_fe_idx : w_mid_idx;
    assign w_rd_data = r_cell[w_rd_idx];

    always_comb begin
        n_cell  = r_cell;
        n_count = r_count;
        n_rsp   = '0;
        n_rsp.status = ST_OK;
        unique case (r_req.action)
            ACT_INSERT: begin
                if (w_full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (PW'(i) > w_ins_pos) begin
                            n_cell[i] = r_cell[(i == 0) ? 0 : i - 1];
                        end else if (PW'(i) == w_ins_pos) begin
                            n_cell[i] = r_req.item_value;
                        end
                    end
                    n_count = r_count + CW'(1);
                end
            end
            ACT_FIND: begin
                if (r_hit) begin
                    n_rsp.found_index = 4'(w_hit_idx);
                end else begin
                    n_rsp.status = ST_NOT_FOUND;
                end
            end
            ACT_DELETE: begin
                if (r_hit) begin
                    n_rsp.found_index = 4'(w_hit_idx);
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (w_at_or_after[i]) begin
                            n_cell[i] = r_cell[(i == CAPACITY - 1) ? i : i + 1];
                        end
                    end
                    n_count = r_count - CW'(1);
                end else begin
                    n_rsp.status = ST_NOT_FOUND;
                end
            end
            ACT_FROM_END: begin
                if (w_fe_ok) begin
                    n_rsp.read_value = w_rd_data;
                end else begin
                    n_rsp.status = ST_NOT_FOUND;
                end
            end
            ACT_MIDDLE: begin
                if (r_count != '0) begin
                    n_rsp.read_value = w_rd_data;
                end else begin
                    n_rsp.status = ST_NOT_FOUND;
                end
            end
            ACT_LENGTH: begin
                n_rsp.status = ST_OK;
            end
            default: begin
                n_rsp.status = ST_NOT_FOUND;
            end
        endcase
        n_rsp.list_length = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.compare) begin
            r_match <= n_match;
        end
        if (i_cmd.select) begin
            r_onehot <= r_match & (~r_match + CAPACITY'(1));
            r_hit    <= |r_match;
        end
        if (i_cmd.commit) begin
            r_cell <= n_cell;
            r_rsp  <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

// ===== rtl/ordered_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Ordered list engine top level
// A result becomes valid once its request has passed the compare, select and commit
// states of the controller; a new request is accepted only back in idle, so requests
// do not overlap, and commit waits while the response register is full.
// Reset: synchronous active low; clears the entry count and handshake state,
// entry cells are not cleared (only occupied cells are ever read).
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_engine_unit_assert.svh"

module ordered_list_engine_unit #(
    parameter int CAPACITY = 16     // list depth, 2 to 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    olist_req_if.sink   i_req,
    olist_rsp_if.source o_rsp
);
    import olist_pkg::*;

    // Command bundle from controller to datapath. The controller walks:
    //   idle    - wait for a request, datapath captures it on accept
    //   compare - every cell compares against the request value in parallel
    //   select  - first occupied matching cell isolated as a one-hot
    //   commit  - cells shift (insert opens a gap, delete closes one),
    //             count updates and the response register loads
    t_cmd w_cmd;
    logic w_in_ready;
    logic w_out_valid;

    olist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    // Datapath: CAPACITY entry cells plus the request and response registers.
    olist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req.payload),
        .o_rsp   (o_rsp.payload)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

    // A request in flight blocks the next one until its commit.
    `OLE_ASSERT_NEXT(a_one_in_flight, i_req.valid && i_req.ready, !i_req.ready,
        "request accepted while previous request in flight")

    // Response valid only ever rises right after a commit.
    `OLE_ASSERT_NOW(a_valid_from_commit, $rose(o_rsp.valid), $past(w_cmd.commit),
        "response valid without commit")

    // Commit never overwrites a response still waiting to be taken.
    `OLE_ASSERT_NOW(a_no_overwrite, w_cmd.commit, !o_rsp.valid || o_rsp.ready,
        "commit while response pending")

    // Reported length never exceeds the list depth.
    `OLE_ASSERT_NOW(a_length_bound, o_rsp.valid, o_rsp.payload.list_length <= CAPACITY,
        "list length above capacity")

endmodule

`default_nettype wire
